// ===== design/hra_pkg.sv =====
package hra_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;

  localparam int MODE_W     = 2;
  localparam int SIZE_W     = 32;
  localparam int KEY_W      = 24;
  localparam int VAL_W      = 32;
  localparam int STATUS_W   = 3;
  localparam int CNT_W      = 7;
  localparam int MULT_W     = 32;
  localparam int COLS_W     = 25;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DRAIN  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_STARTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DRAINED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  localparam logic [CFG_ADDR_W-1:0] REG_HASH_MULTIPLIER = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COLUMN_COUNT    = 2'd1;

  localparam logic [MULT_W-1:0] HASH_MULTIPLIER_RESET = 32'd107;
  localparam logic [COLS_W-1:0] COLUMN_COUNT_RESET    = 25'd16777216;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] sum;
  } slot_entry_t;

endpackage

// ===== design/hra_in_if.sv =====
interface hra_in_if;
  logic                             valid;
  logic                             ready;
  logic [hra_pkg::MODE_W-1:0]       mode;
  logic [hra_pkg::SIZE_W-1:0]       size_estimate;
  logic [hra_pkg::KEY_W-1:0]        column_key;
  logic signed [hra_pkg::VAL_W-1:0] left_value;
  logic signed [hra_pkg::VAL_W-1:0] right_value;

  modport source(output valid, mode, size_estimate, column_key, left_value, right_value,
                 input ready);
  modport sink(input valid, mode, size_estimate, column_key, left_value, right_value,
               output ready);
endinterface

// ===== design/hra_out_if.sv =====
interface hra_out_if;
  logic                             valid;
  logic                             ready;
  logic [hra_pkg::STATUS_W-1:0]     status;
  logic [hra_pkg::KEY_W-1:0]        out_key;
  logic signed [hra_pkg::VAL_W-1:0] out_value;
  logic [hra_pkg::CNT_W-1:0]        row_nonzeros;
  logic                             last;

  modport source(output valid, status, out_key, out_value, row_nonzeros, last,
                 input ready);
  modport sink(input valid, status, out_key, out_value, row_nonzeros, last,
               output ready);
endinterface

// ===== design/hra_cfg_if.sv =====
interface hra_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [hra_pkg::CFG_ADDR_W-1:0]   addr;
  logic [hra_pkg::CFG_DATA_W-1:0]   data;

  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

// ===== design/hra_slot_ram.sv =====
module hra_slot_ram #(
  parameter int DEPTH  = hra_pkg::TABLE_DEPTH_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  hra_pkg::slot_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output hra_pkg::slot_entry_t rd_data
);

  hra_pkg::slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/hra_ctrl.sv =====
module hra_ctrl #(
  parameter int TABLE_DEPTH = hra_pkg::TABLE_DEPTH_DEFAULT,
  parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  hra_in_if.sink                      items,
  hra_out_if.source                   results,
  input  logic [hra_pkg::MULT_W-1:0]  hash_multiplier,
  input  logic [hra_pkg::COLS_W-1:0]  column_count,
  output logic                        wr_en,
  output logic [IDX_W-1:0]            wr_addr,
  output hra_pkg::slot_entry_t        wr_data,
  output logic                        rd_en,
  output logic [IDX_W-1:0]            rd_addr,
  input  hra_pkg::slot_entry_t        rd_data
);

  localparam int CAP_LOG = $clog2(TABLE_DEPTH + 1) - 1;
  localparam int CAP     = 1 << CAP_LOG;
  localparam logic [IDX_W-1:0] CAP_MASK = IDX_W'(CAP - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FETCH  = 3'd4;

  logic [2:0]                       state;
  logic [TABLE_DEPTH-1:0]           slot_valid;
  logic [hra_pkg::CNT_W-1:0]        count;
  logic [hra_pkg::CNT_W-1:0]        emitted;
  logic [IDX_W-1:0]                 mask;
  logic                             table_on;
  logic [IDX_W-1:0]                 probe;
  logic [IDX_W-1:0]                 probe_n;
  logic [IDX_W-1:0]                 scan;

  logic [hra_pkg::MODE_W-1:0]       item_mode;
  logic [hra_pkg::SIZE_W-1:0]       item_size;
  logic [hra_pkg::KEY_W-1:0]        item_key;
  logic signed [hra_pkg::VAL_W-1:0] item_left;
  logic signed [hra_pkg::VAL_W-1:0] item_right;
  logic [hra_pkg::VAL_W-1:0]        prod;

  logic                             res_valid;
  logic [hra_pkg::STATUS_W-1:0]     res_status;
  logic [hra_pkg::KEY_W-1:0]        res_key;
  logic [hra_pkg::VAL_W-1:0]        res_value;
  logic [hra_pkg::CNT_W-1:0]        res_count;
  logic                             res_last;

  logic                             out_free;
  logic [hra_pkg::SIZE_W-1:0]       est;
  logic [IDX_W-1:0]                 smear;
  logic [IDX_W-1:0]                 start_mask;
  logic [2*IDX_W-1:0]               hash_full;
  logic [IDX_W-1:0]                 hash_slot;
  logic [IDX_W-1:0]                 probe_step;
  logic                             hit;
  logic                             empty;
  logic                             probe_last;
  logic                             drain_last;
  logic [hra_pkg::VAL_W-1:0]        sum_new;

  logic                             emit;
  logic [hra_pkg::STATUS_W-1:0]     e_status;
  logic [hra_pkg::KEY_W-1:0]        e_key;
  logic [hra_pkg::VAL_W-1:0]        e_value;
  logic [hra_pkg::CNT_W-1:0]        e_count;
  logic                             e_last;

  assign items.ready = (state == S_IDLE);
  assign out_free    = !res_valid || results.ready;

  assign results.valid        = res_valid;
  assign results.status       = res_status;
  assign results.out_key      = res_key;
  assign results.out_value    = $signed(res_value);
  assign results.row_nonzeros = res_count;
  assign results.last         = res_last;

  always_comb begin
    est = (item_size > {{(hra_pkg::SIZE_W - hra_pkg::COLS_W){1'b0}}, column_count})
        ? {{(hra_pkg::SIZE_W - hra_pkg::COLS_W){1'b0}}, column_count} : item_size;
    smear = IDX_W'(est - 32'd1);
    for (int i = 0; i < IDX_W; i++) begin
      smear = smear | (smear >> 1);
    end
    start_mask = (est >= 32'(CAP)) ? CAP_MASK : smear;
  end

  assign hash_full  = {{IDX_W{1'b0}}, item_key[IDX_W-1:0]}
                    * {{IDX_W{1'b0}}, hash_multiplier[IDX_W-1:0]};
  assign hash_slot  = hash_full[IDX_W-1:0] & mask;
  assign probe_step = (probe + IDX_W'(1)) & mask;
  assign hit        = slot_valid[probe] && (rd_data.key == item_key);
  assign empty      = !slot_valid[probe];
  assign probe_last = (probe_n == mask);
  assign sum_new    = rd_data.sum + prod;
  assign drain_last = (hra_pkg::CNT_W'(emitted + 1'b1) == count);

  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = probe;
    wr_en        = 1'b0;
    wr_addr      = probe;
    wr_data.key  = item_key;
    wr_data.sum  = hit ? sum_new : prod;
    case (state)
      S_DECODE: begin
        if (item_mode == hra_pkg::MODE_INSERT && table_on) begin
          rd_en   = 1'b1;
          rd_addr = hash_slot;
        end
      end
      S_CHECK: begin
        if (hit || empty) begin
          wr_en = out_free;
        end else if (!probe_last) begin
          rd_en   = 1'b1;
          rd_addr = probe_step;
        end
      end
      S_SCAN: begin
        if (slot_valid[scan]) begin
          rd_en   = 1'b1;
          rd_addr = scan;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    emit     = 1'b0;
    e_status = hra_pkg::ST_STARTED;
    e_key    = '0;
    e_value  = '0;
    e_count  = count;
    e_last   = 1'b1;
    case (state)
      S_DECODE: begin
        case (item_mode)
          hra_pkg::MODE_START: begin
            emit    = out_free;
            e_count = '0;
          end
          hra_pkg::MODE_INSERT: begin
            if (!table_on) begin
              emit     = out_free;
              e_status = hra_pkg::ST_FULL;
              e_key    = item_key;
            end
          end
          hra_pkg::MODE_DRAIN: begin
            if (!table_on || count == '0) begin
              emit     = out_free;
              e_status = hra_pkg::ST_EMPTY;
            end
          end
          default: begin
          end
        endcase
      end
      S_CHECK: begin
        e_key = item_key;
        if (hit) begin
          emit     = out_free;
          e_status = hra_pkg::ST_INSERTED;
          e_value  = sum_new;
        end else if (empty) begin
          emit     = out_free;
          e_status = hra_pkg::ST_INSERTED;
          e_value  = prod;
          e_count  = hra_pkg::CNT_W'(count + 1'b1);
        end else if (probe_last) begin
          emit     = out_free;
          e_status = hra_pkg::ST_FULL;
        end
      end
      S_FETCH: begin
        emit     = out_free;
        e_status = hra_pkg::ST_DRAINED;
        e_key    = rd_data.key;
        e_value  = rd_data.sum;
        e_last   = drain_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      count      <= '0;
      emitted    <= '0;
      mask       <= '0;
      table_on   <= 1'b0;
      probe      <= '0;
      probe_n    <= '0;
      scan       <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (items.valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (item_mode)
            hra_pkg::MODE_START: begin
              if (out_free) begin
                slot_valid <= '0;
                count      <= '0;
                table_on   <= (est != '0);
                mask       <= (est != '0) ? start_mask : '0;
                state      <= S_IDLE;
              end
            end
            hra_pkg::MODE_INSERT: begin
              if (!table_on) begin
                if (out_free) begin
                  state <= S_IDLE;
                end
              end else begin
                probe   <= hash_slot;
                probe_n <= '0;
                state   <= S_CHECK;
              end
            end
            hra_pkg::MODE_DRAIN: begin
              if (!table_on || count == '0) begin
                if (out_free) begin
                  state <= S_IDLE;
                end
              end else begin
                scan    <= '0;
                emitted <= '0;
                state   <= S_SCAN;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_CHECK: begin
          if (hit || empty || probe_last) begin
            if (out_free) begin
              if (empty) begin
                slot_valid[probe] <= 1'b1;
                count             <= hra_pkg::CNT_W'(count + 1'b1);
              end
              state <= S_IDLE;
            end
          end else begin
            probe   <= probe_step;
            probe_n <= probe_n + IDX_W'(1);
          end
        end
        S_SCAN: begin
          if (slot_valid[scan]) begin
            state <= S_FETCH;
          end else begin
            scan <= scan + IDX_W'(1);
          end
        end
        S_FETCH: begin
          if (out_free) begin
            emitted <= hra_pkg::CNT_W'(emitted + 1'b1);
            scan    <= scan + IDX_W'(1);
            state   <= drain_last ? S_IDLE : S_SCAN;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && items.valid) begin
      item_mode  <= items.mode;
      item_size  <= items.size_estimate;
      item_key   <= items.column_key;
      item_left  <= items.left_value;
      item_right <= items.right_value;
    end
    if (state == S_DECODE) begin
      prod <= item_left * item_right;
    end
    if (emit) begin
      res_status <= e_status;
      res_key    <= e_key;
      res_value  <= e_value;
      res_count  <= e_count;
      res_last   <= e_last;
    end
  end

endmodule

// ===== design/hash_row_accumulator.sv =====
// Hash row accumulator for one row of a sparse matrix product.
// Channels: items (mode, size_estimate, column_key, left_value, right_value),
// results (status, out_key, out_value, row_nonzeros, last) and cfg, a write
// channel that sets hash_multiplier (index 0) and column_count (index 1).
// cfg is always ready; write it only while the block is idle.
// One item is taken at a time; items.ready is high while the block waits.
// Start, mode 3, an insert without a table and a drain of an empty or missing
// table finish in the decode state, without a memory read.
// Insert: decode, then one check per probe slot, paced by the registered read
// of the slot memory in the probe loop; at most TABLE_DEPTH probes.
// Drain: decode, then a scan step per slot up to the last occupied one, plus
// a fetch step per emitted entry for its memory read.
// Results leave through an output register; a stalled receiver holds the
// current result and the block waits at its next result until it is taken.
// Reset clears the occupancy bits, the row count and the table, so the block
// acts as a row with no table, and restores the register defaults.
// Key and sum storage are not cleared and need no clearing pass.
module hash_row_accumulator #(
  parameter int TABLE_DEPTH = hra_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  hra_in_if.sink    items,
  hra_out_if.source results,
  hra_cfg_if.sink   cfg
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [hra_pkg::MULT_W-1:0] hash_multiplier;
  logic [hra_pkg::COLS_W-1:0] column_count;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  hra_pkg::slot_entry_t wr_data;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  hra_pkg::slot_entry_t rd_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_multiplier <= hra_pkg::HASH_MULTIPLIER_RESET;
      column_count    <= hra_pkg::COLUMN_COUNT_RESET;
    end else if (cfg.valid) begin
      case (cfg.addr)
        hra_pkg::REG_HASH_MULTIPLIER: hash_multiplier <= cfg.data;
        hra_pkg::REG_COLUMN_COUNT:    column_count    <= cfg.data[hra_pkg::COLS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hra_slot_ram #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hra_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .items           (items),
    .results         (results),
    .hash_multiplier (hash_multiplier),
    .column_count    (column_count),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

endmodule

// ===== design/hra_checker.sv =====
module hra_checker #(
  parameter int TABLE_DEPTH = hra_pkg::TABLE_DEPTH_DEFAULT
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [hra_pkg::STATUS_W-1:0] status,
  input logic [hra_pkg::KEY_W-1:0]    out_key,
  input logic [hra_pkg::VAL_W-1:0]    out_value,
  input logic [hra_pkg::CNT_W-1:0]    row_nonzeros,
  input logic                         last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(out_key)
      && $stable(out_value) && $stable(row_nonzeros) && $stable(last))
    else $error("result changed while stalled");

  a_start: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == hra_pkg::ST_STARTED |-> row_nonzeros == '0 && out_key == '0
      && out_value == '0 && last)
    else $error("start result with nonzero fields or without last");

  a_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != hra_pkg::ST_DRAINED |-> last)
    else $error("single result item without last");

  a_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> row_nonzeros <= hra_pkg::CNT_W'(TABLE_DEPTH))
    else $error("row count above table depth");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == hra_pkg::ST_EMPTY || status == hra_pkg::ST_FULL)
      |-> out_value == '0)
    else $error("empty or full result with a value");

endmodule

bind hash_row_accumulator hra_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (results.valid),
  .res_ready    (results.ready),
  .status       (results.status),
  .out_key      (results.out_key),
  .out_value    (results.out_value),
  .row_nonzeros (results.row_nonzeros),
  .last         (results.last)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hra_pkg::*;

  localparam int          DEPTH         = TABLE_DEPTH_DEFAULT;
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
  localparam int          RANDOM_ITEMS  = 130;
  localparam int          PHASE_ITEMS   = 20;
  localparam int          SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] size;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  lhs;
    logic [VAL_W-1:0]  rhs;
    bit                wait_quiet;
  } work_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [VAL_W-1:0]    value;
    logic [CNT_W-1:0]    nonzeros;
    logic                last;
  } row_result_t;

  logic clk;
  logic rst;

  hra_in_if  items_if ();
  hra_out_if results_if ();
  hra_cfg_if cfg_if ();

  hash_row_accumulator dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  work_item_t  pending_items[$];
  row_result_t expected_results[$];
  int          results_due;
  int          results_done;
  int          random_count;
  int          mismatches;
  int          send_gap;
  int          hold_gap;
  bit          steady_flow;
  int unsigned cycle_count;

  logic [MULT_W-1:0] hash_mult;
  logic [COLS_W-1:0] col_cap;
  bit                table_live;
  logic [CNT_W-1:0]  probe_mask;
  logic [CNT_W-1:0]  distinct;
  bit                occupied[DEPTH];
  logic [KEY_W-1:0]  held_key[DEPTH];
  logic [VAL_W-1:0]  held_sum[DEPTH];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 5);
      default: return $urandom();
    endcase
  endfunction

  function automatic void expect_result(logic [STATUS_W-1:0] st, logic [KEY_W-1:0] key,
                                        logic [VAL_W-1:0] value, logic last);
    row_result_t r;
    r.status   = st;
    r.key      = key;
    r.value    = value;
    r.nonzeros = distinct;
    r.last     = last;
    expected_results.push_back(r);
    results_due++;
  endfunction

  function automatic void predict_row_op(work_item_t it);
    longint unsigned want;
    int unsigned     slots;
    int unsigned     slot;
    int unsigned     n;
    int unsigned     total;
    int unsigned     emitted;
    logic [VAL_W-1:0] product;
    logic [63:0]     hashed;
    bit              found;
    case (it.mode)
      MODE_START: begin
        want = (it.size > SIZE_W'(col_cap)) ? 64'(col_cap) : 64'(it.size);
        occupied = '{default: 1'b0};
        distinct = '0;
        if (want == 0) begin
          table_live = 1'b0;
          probe_mask = '0;
        end else begin
          slots = 1;
          while (slots < DEPTH && slots < want) slots *= 2;
          table_live = 1'b1;
          probe_mask = CNT_W'(slots - 1);
        end
        expect_result(ST_STARTED, '0, '0, 1'b1);
      end
      MODE_INSERT: begin
        product = it.lhs * it.rhs;
        if (!table_live) begin
          expect_result(ST_FULL, it.key, '0, 1'b1);
        end else begin
          hashed = 64'(it.key) * 64'(hash_mult);
          slot   = 32'(hashed[CNT_W-1:0] & probe_mask);
          found  = 1'b0;
          for (n = 0; n <= probe_mask; n++) begin
            if (!found) begin
              if (occupied[slot] && held_key[slot] == it.key) begin
                held_sum[slot] = held_sum[slot] + product;
                found = 1'b1;
              end else if (!occupied[slot]) begin
                occupied[slot] = 1'b1;
                held_key[slot] = it.key;
                held_sum[slot] = product;
                distinct = distinct + 1'b1;
                found = 1'b1;
              end else begin
                slot = (slot + 1) & 32'(probe_mask);
              end
            end
          end
          if (found) expect_result(ST_INSERTED, it.key, held_sum[slot], 1'b1);
          else expect_result(ST_FULL, it.key, '0, 1'b1);
        end
      end
      MODE_DRAIN: begin
        total = 0;
        if (table_live) begin
          for (n = 0; n <= probe_mask; n++) if (occupied[n]) total++;
        end
        if (total == 0) begin
          expect_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          emitted = 0;
          for (n = 0; n <= probe_mask; n++) begin
            if (occupied[n]) begin
              emitted++;
              expect_result(ST_DRAINED, held_key[n], held_sum[n], emitted == total);
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void queue_item(logic [MODE_W-1:0] mode, logic [SIZE_W-1:0] size,
                                     logic [KEY_W-1:0] key, logic [VAL_W-1:0] lhs,
                                     logic [VAL_W-1:0] rhs, bit quiet, bit counted);
    work_item_t it;
    it.mode       = mode;
    it.size       = size;
    it.key        = key;
    it.lhs        = lhs;
    it.rhs        = rhs;
    it.wait_quiet = quiet;
    pending_items.push_back(it);
    if (counted) random_count++;
  endfunction

  // driver: hold an item until taken, then maybe pause
  always @(posedge clk) begin
    if (rst) begin
      items_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (items_if.valid && items_if.ready) begin
        predict_row_op(pending_items.pop_front());
        send_gap = pick_gap();
      end
      if (items_if.valid && !items_if.ready) begin
      end else if (send_gap != 0) begin
        send_gap--;
        items_if.valid <= 1'b0;
      end else if (pending_items.size() == 0 ||
                   (pending_items[0].wait_quiet &&
                    results_due != results_done + int'(results_if.valid && results_if.ready)))
      begin
        items_if.valid <= 1'b0;
      end else begin
        items_if.valid         <= 1'b1;
        items_if.mode          <= pending_items[0].mode;
        items_if.size_estimate <= pending_items[0].size;
        items_if.column_key    <= pending_items[0].key;
        items_if.left_value    <= pending_items[0].lhs;
        items_if.right_value   <= pending_items[0].rhs;
      end
    end
  end

  // monitor: check each item against the oldest expectation, stall at random
  always @(posedge clk) begin
    row_result_t want;
    if (rst) begin
      results_if.ready <= 1'b0;
      hold_gap = 0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        results_done <= results_done + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d key 0x%0h value 0x%0h",
                 results_if.status, results_if.out_key, results_if.out_value);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(results_if.status));
          check_field("out_key", 32'(want.key), 32'(results_if.out_key));
          check_field("out_value", want.value, results_if.out_value);
          check_field("row_nonzeros", 32'(want.nonzeros), 32'(results_if.row_nonzeros));
          check_field("last", 32'(want.last), 32'(results_if.last));
        end
      end
      if (hold_gap != 0) begin
        hold_gap--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
        hold_gap = ($urandom_range(0, 5) == 0) ? pick_gap() : 0;
      end
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= index;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (index == REG_HASH_MULTIPLIER) hash_mult = value;
    else col_cap = value[COLS_W-1:0];
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || items_if.valid || results_due != results_done)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_row();
    logic [KEY_W-1:0]  pool[8];
    logic [SIZE_W-1:0] estimate;
    int unsigned       pick;
    int unsigned       pool_n;
    int unsigned       inserts;
    int unsigned       i;
    pick = $urandom_range(0, 99);
    if (pick < 8) estimate = '0;
    else if (pick < 18) estimate = $urandom();
    else if (pick < 24) estimate = $urandom_range(17, 200);
    else estimate = $urandom_range(1, 16);
    if ($urandom_range(0, 9) != 0)
      queue_item(MODE_START, estimate, KEY_W'($urandom()), $urandom(), $urandom(),
                 $urandom_range(0, 19) == 0, 1'b1);
    pool_n = $urandom_range(1, 8);
    for (i = 0; i < pool_n; i++)
      pool[i] = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom_range(0, 15)) : KEY_W'($urandom());
    inserts = $urandom_range(0, 12);
    for (i = 0; i < inserts; i++) begin
      if ($urandom_range(0, 19) == 0)
        queue_item(MODE_IGNORED, $urandom(), KEY_W'($urandom()), $urandom(), $urandom(), 1'b0,
                   1'b0);
      if ($urandom_range(0, 24) == 0)
        queue_item(MODE_DRAIN, $urandom(), KEY_W'($urandom()), $urandom(), $urandom(), 1'b0,
                   1'b1);
      queue_item(MODE_INSERT, $urandom(), pool[$urandom_range(0, pool_n - 1)], pick_value(),
                 pick_value(), $urandom_range(0, 29) == 0, 1'b1);
    end
    queue_item(MODE_DRAIN, $urandom(), KEY_W'($urandom()), $urandom(), $urandom(),
               $urandom_range(0, 9) == 0, 1'b1);
    if ($urandom_range(0, 4) == 0)
      queue_item(MODE_DRAIN, $urandom(), KEY_W'($urandom()), $urandom(), $urandom(), 1'b0,
                 1'b1);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("hash_row_accumulator verification failed");
    $finish;
  end

  initial begin
    logic [MULT_W-1:0]     mult;
    logic [CFG_DATA_W-1:0] cols;
    int                    phase;
    int                    phase_base;
    int                    i;

    rst                    = 1'b1;
    items_if.valid         = 1'b0;
    items_if.mode          = '0;
    items_if.size_estimate = '0;
    items_if.column_key    = '0;
    items_if.left_value    = '0;
    items_if.right_value   = '0;
    results_if.ready       = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.addr            = '0;
    cfg_if.data            = '0;
    results_due            = 0;
    results_done           = 0;
    random_count           = 0;
    mismatches             = 0;
    steady_flow            = 1'b0;
    hash_mult              = HASH_MULTIPLIER_RESET;
    col_cap                = COLUMN_COUNT_RESET;
    table_live             = 1'b0;
    probe_mask             = '0;
    distinct               = '0;
    occupied               = '{default: 1'b0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // no table yet: insert and drain before any start, plus an ignored mode
    queue_item(MODE_INSERT, '0, 24'h00_1234, 32'd3, 32'd5, 1'b0, 1'b0);
    queue_item(MODE_DRAIN, '0, '0, '0, '0, 1'b0, 1'b0);
    queue_item(MODE_IGNORED, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
               1'b0);
    // zero estimate leaves the row without a table
    queue_item(MODE_START, '0, '0, '0, '0, 1'b0, 1'b0);
    queue_item(MODE_INSERT, '0, 24'hFF_FFFF, 32'd7, 32'd9, 1'b0, 1'b0);
    queue_item(MODE_DRAIN, '0, '0, '0, '0, 1'b0, 1'b0);
    // largest estimate, clamped to the full table; wrapping products and sums
    queue_item(MODE_START, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, 1'b0);
    queue_item(MODE_INSERT, '0, 24'h00_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_item(MODE_INSERT, '0, 24'hFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
    queue_item(MODE_INSERT, '0, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b0, 1'b0);
    queue_item(MODE_DRAIN, '0, '0, '0, '0, 1'b0, 1'b0);
    queue_item(MODE_DRAIN, '0, '0, '0, '0, 1'b1, 1'b0);
    // one-slot table: claim, full, accumulate
    queue_item(MODE_START, 32'd1, '0, '0, '0, 1'b0, 1'b0);
    queue_item(MODE_INSERT, '0, 24'h5A_5A5A, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
    queue_item(MODE_INSERT, '0, 24'hA5_A5A5, 32'd2, 32'd2, 1'b0, 1'b0);
    queue_item(MODE_INSERT, '0, 24'h5A_5A5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_item(MODE_DRAIN, '0, '0, '0, '0, 1'b0, 1'b0);
    // estimate 3 rounds up to four slots; the fifth key finds the table full
    queue_item(MODE_START, 32'd3, '0, '0, '0, 1'b0, 1'b0);
    queue_item(MODE_INSERT, '0, 24'h00_0001, 32'd10, 32'd1, 1'b0, 1'b0);
    queue_item(MODE_INSERT, '0, 24'h00_0002, 32'd20, 32'd1, 1'b0, 1'b0);
    queue_item(MODE_INSERT, '0, 24'hAB_CDEF, 32'd30, 32'd1, 1'b0, 1'b0);
    queue_item(MODE_INSERT, '0, 24'h12_3456, 32'd40, 32'd1, 1'b0, 1'b0);
    queue_item(MODE_INSERT, '0, 24'h80_0000, 32'd50, 32'd1, 1'b0, 1'b0);
    queue_item(MODE_DRAIN, '0, '0, '0, '0, 1'b0, 1'b0);
    // present but empty table
    queue_item(MODE_START, 32'd8, '0, '0, '0, 1'b0, 1'b0);
    queue_item(MODE_DRAIN, '0, '0, '0, '0, 1'b0, 1'b0);
    wait_idle();

    phase = 0;
    while (random_count < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          mult = 32'hFFFF_FFFF;
          cols = 32'd16777216;
        end
        1: begin
          mult = 32'd1;
          cols = 32'd1;
        end
        2: begin
          mult = $urandom() | 32'd1;
          cols = 32'd0;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: mult = 32'd1;
            1: mult = 32'hFFFF_FFFF;
            default: mult = $urandom() | 32'd1;
          endcase
          case ($urandom_range(0, 3))
            0: cols = 32'd16777216;
            1: cols = 32'd1;
            2: cols = $urandom_range(2, 40);
            default: cols = $urandom_range(41, 16777216);
          endcase
        end
      endcase
      write_reg(REG_HASH_MULTIPLIER, mult);
      write_reg(REG_COLUMN_COUNT, cols);
      steady_flow = ($urandom_range(0, 3) == 0);
      phase_base  = random_count;
      if (phase == 0) begin
        // fill the whole table, overflow it, drain every slot
        queue_item(MODE_START, 32'd64 + $urandom_range(0, 1000), '0, '0, '0, 1'b0, 1'b1);
        for (i = 0; i < DEPTH + 2; i++)
          queue_item(MODE_INSERT, $urandom(), (KEY_W'($urandom()) & 24'hFF_FF00) | KEY_W'(i),
                     pick_value(), pick_value(), 1'b0, 1'b1);
        queue_item(MODE_DRAIN, $urandom(), KEY_W'($urandom()), $urandom(), $urandom(), 1'b0,
                   1'b1);
      end
      while (random_count - phase_base < PHASE_ITEMS && random_count < RANDOM_ITEMS)
        queue_row();
      wait_idle();
      phase++;
    end

    if (mismatches == 0) begin
      $display("hash_row_accumulator verification clean");
    end else begin
      $display("hash_row_accumulator verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/hra_pkg.sv
design/hra_in_if.sv
design/hra_out_if.sv
design/hra_cfg_if.sv
design/hra_slot_ram.sv
design/hra_ctrl.sv
design/hash_row_accumulator.sv
design/hra_checker.sv
verif/testbench.sv
